// ----- rtl/dpd_pkg.sv -----
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared types, constants and calendar tables for the dotted date parser.
// ----------------------------------------------------------------------------
package dpd_pkg;

  // field widths of the result item
  localparam int TotalW   = 25;
  localparam int YearOutW = 16;
  localparam int MonthW   = 4;
  localparam int DayW     = 5;
  localparam int InDataW  = 8;
  localparam int OutDataW = 56;

  // defaults for the top level parameters
  localparam int YearBitsDefault  = 16;
  localparam int FifoDepthDefault = 4;

  // characters and arithmetic constants
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam int         Ten       = 10;
  localparam int         DaysPerYear = 365;
  localparam logic [3:0] MonthMax  = 4'd12;
  localparam logic [3:0] MonthSat  = 4'd15;
  localparam logic [5:0] DaySat    = 6'd63;

  // parser phase
  typedef enum logic [1:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY,
    PH_SKIP
  } phase_t;

  // how an open field is closed
  typedef enum logic [1:0] {
    END_DOT,
    END_OTHER,
    END_STRING
  } end_kind_t;

  // parsed fields beside the year, passed from the parser to the back end
  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              ok;
  } date_fields_t;

  // common-year month length, month given as 1..12
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    case (m)
      4'd2:                      r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

  // days in the year before the first of month m
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/dotted_date_parser_to_day_count_top.sv -----
// ----------------------------------------------------------------------------
// dotted_date_parser_to_day_count_top
// Date text "YEAR[.MONTH[.DAY]]" in, one byte per item; day count out.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle while the queue is not full; a result
//   item every cycle if strings are one byte long and the receiver is ready.
// Path: the record of the final byte passes the queue write, the multiply
//   stage and the output register in order, and can wait at each on a stall.
// Reset: rst clears the parser, the queue and both pipeline valids; the
//   block takes bytes in the first cycle after reset.
module dotted_date_parser_to_day_count_top
  import dpd_pkg::*;
#(
  parameter int YEAR_BITS  = YearBitsDefault,
  parameter int FIFO_DEPTH = FifoDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // [7:0] character
  input  logic                s_tlast,   // last byte of the string
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [24:0] day_count, [40:25] year,
                                         // [44:41] month, [49:45] day, zero fill
  output logic                m_tuser    // ok
);

  localparam int RecW = YEAR_BITS + $bits(date_fields_t);

  logic                 accept;
  logic                 push;
  logic [YEAR_BITS-1:0] push_year;
  date_fields_t         push_fields;
  logic                 pop;
  logic                 q_full;
  logic                 q_empty;
  logic [RecW-1:0]      q_rd;
  logic [YEAR_BITS-1:0] q_year;
  date_fields_t         q_fields;

  // input handshake
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign q_year   = q_rd[RecW-1 -: YEAR_BITS];
  assign q_fields = q_rd[$bits(date_fields_t)-1:0];

  dpd_front #(
    .YEAR_BITS (YEAR_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .character   (s_tdata),
    .last        (s_tlast),
    .push        (push),
    .push_year   (push_year),
    .push_fields (push_fields)
  );

  dpd_fifo #(
    .WIDTH (RecW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data ({push_year, push_fields}),
    .pop     (pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  dpd_back #(
    .YEAR_BITS (YEAR_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_year   (q_year),
    .q_fields (q_fields),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- rtl/dpd_front.sv -----
// ----------------------------------------------------------------------------
// dpd_front
// Byte parser: accumulates year, month and day digits, checks separators
// and pushes one parsed record per string into the queue.
// ----------------------------------------------------------------------------
module dpd_front
  import dpd_pkg::*;
#(
  parameter int YEAR_BITS = YearBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [InDataW-1:0]   character,
  input  logic                 last,
  output logic                 push,
  output logic [YEAR_BITS-1:0] push_year,
  output date_fields_t         push_fields
);

  localparam int AccW = YEAR_BITS + 5;
  localparam logic [YEAR_BITS:0] YearLim = {1'b1, {YEAR_BITS{1'b0}}};

  typedef struct packed {
    phase_t             ph;
    logic [YEAR_BITS:0] ya;
    logic [3:0]         ma;
    logic [5:0]         da;
    logic               seen;
    logic [MonthW-1:0]  mk;
    logic [DayW-1:0]    dk;
    logic               fl;
  } pstate_t;

  localparam pstate_t StateInit = '{
    ph: PH_YEAR, ya: '0, ma: 4'd0, da: 6'd0, seen: 1'b0,
    mk: 4'd1, dk: 5'd1, fl: 1'b0
  };

  // field close: range check, keep the value, move on or give up
  function automatic pstate_t close_field(input pstate_t s, input end_kind_t kind);
    pstate_t r;
    r = s;
    case (s.ph)
      PH_YEAR: begin
        if (!s.seen || s.ya >= YearLim) begin
          r.ya = '0;
          r.mk = 4'd1;
          r.dk = 5'd1;
          r.fl = 1'b1;
          r.ph = PH_SKIP;
        end else if (kind == END_DOT) begin
          r.ph   = PH_MONTH;
          r.seen = 1'b0;
        end else if (kind == END_OTHER) begin
          r.fl = 1'b1;
          r.ph = PH_SKIP;
        end
      end
      PH_MONTH: begin
        if (!s.seen || s.ma == 4'd0 || s.ma > MonthMax) begin
          r.fl = 1'b1;
          r.ph = PH_SKIP;
        end else begin
          r.mk = s.ma;
          if (kind == END_DOT) begin
            r.ph   = PH_DAY;
            r.seen = 1'b0;
          end else if (kind == END_OTHER) begin
            r.fl = 1'b1;
            r.ph = PH_SKIP;
          end
        end
      end
      PH_DAY: begin
        if (!s.seen || s.da == 6'd0 || s.da > 6'(month_len(s.mk))) begin
          r.fl = 1'b1;
          r.ph = PH_SKIP;
        end else begin
          r.dk = s.da[DayW-1:0];
          if (kind != END_STRING) begin
            r.fl = 1'b1;
            r.ph = PH_SKIP;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  pstate_t st;
  pstate_t st_next;
  pstate_t st_step;
  pstate_t st_end;

  logic             is_digit;
  logic [3:0]       digit;
  logic [AccW-1:0]  year_v;
  logic [7:0]       month_v;
  logic [9:0]       day_v;

  assign is_digit = character inside {[CharZero:CharNine]};
  assign digit    = character[3:0];
  assign year_v   = AccW'(st.ya) * AccW'(Ten) + AccW'(digit);
  assign month_v  = 8'(st.ma) * 8'(Ten) + 8'(digit);
  assign day_v    = 10'(st.da) * 10'(Ten) + 10'(digit);

  // one byte: digit accumulate or separator check
  always_comb begin
    st_step = st;
    if (st.ph != PH_SKIP) begin
      if (is_digit) begin
        st_step.seen = 1'b1;
        case (st.ph)
          PH_YEAR: begin
            if (st.ya >= YearLim || year_v > AccW'(YearLim)) begin
              st_step.ya = YearLim;
            end else begin
              st_step.ya = year_v[YEAR_BITS:0];
            end
          end
          PH_MONTH: begin
            st_step.ma = (month_v > 8'(MonthSat)) ? MonthSat : month_v[3:0];
          end
          default: begin
            st_step.da = (day_v > 10'(DaySat)) ? DaySat : day_v[5:0];
          end
        endcase
      end else begin
        st_step = close_field(st, (character == CharDot) ? END_DOT : END_OTHER);
      end
    end
  end

  // end of string closes the open field
  always_comb begin
    st_end = st_step;
    if (st_step.ph != PH_SKIP) begin
      st_end = close_field(st_step, END_STRING);
    end
  end

  // next state: back to the start after the final byte
  always_comb begin
    st_next = st;
    if (accept) begin
      st_next = last ? StateInit : st_step;
    end
  end

  // record for the queue
  always_comb begin
    push              = accept && last;
    push_year         = st_end.ya[YEAR_BITS-1:0];
    push_fields.month = st_end.mk;
    push_fields.day   = st_end.dk;
    push_fields.ok    = !st_end.fl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= StateInit;
    end else begin
      st <= st_next;
    end
  end

endmodule

// ----- rtl/dpd_fifo.sv -----
// ----------------------------------------------------------------------------
// dpd_fifo
// Small record queue between the parser and the day count back end.
// ----------------------------------------------------------------------------
module dpd_fifo
  import dpd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = FifoDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/dpd_back.sv -----
// ----------------------------------------------------------------------------
// dpd_back
// Day count back end: year times 365 in one stage, the sum and the
// packed result item in the output register.
// ----------------------------------------------------------------------------
module dpd_back
  import dpd_pkg::*;
#(
  parameter int YEAR_BITS = YearBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  logic [YEAR_BITS-1:0] q_year,
  input  date_fields_t         q_fields,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutDataW-1:0]  m_tdata,
  output logic                 m_tuser
);

  localparam int ProdW = YEAR_BITS + 9;
  localparam int SumW  = (ProdW + 1 > TotalW) ? ProdW + 1 : TotalW;

  logic                 s1_valid;
  logic [ProdW-1:0]     s1_prod;
  logic [8:0]           s1_before;
  logic [YEAR_BITS-1:0] s1_year;
  date_fields_t         s1_fields;

  logic                 out_adv;
  logic                 s1_load;
  logic [SumW-1:0]      sum;

  // pipeline advance
  assign out_adv = !m_tvalid || m_tready;
  assign s1_load = !s1_valid || out_adv;
  assign pop     = s1_load && !q_empty;

  assign sum = SumW'(s1_prod) + SumW'(s1_before) + SumW'(s1_fields.day) - SumW'(1);

  // stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= !q_empty;
    end
  end

  // stage one payload: constant multiply and month table
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_prod   <= ProdW'(q_year) * ProdW'(DaysPerYear);
      s1_before <= days_before(q_fields.month);
      s1_year   <= q_year;
      s1_fields <= q_fields;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      m_tdata <= {6'd0, s1_fields.day, s1_fields.month,
                  YearOutW'(s1_year), TotalW'(sum)};
      m_tuser <= s1_fields.ok;
    end
  end

endmodule

// ----- rtl/dpd_checker.sv -----
// ----------------------------------------------------------------------------
// dpd_checker
// Port-level checks on the date parser result stream.
// ----------------------------------------------------------------------------
module dpd_checker
  import dpd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata,
  input logic                m_tuser
);

  logic [MonthW-1:0] month;
  logic [DayW-1:0]   day;

  assign month = m_tdata[44:41];
  assign day   = m_tdata[49:45];

  // a stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  // no result item right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item valid after reset");

  // month and day always lie in range, defaults included
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> month >= 4'd1 && month <= MonthMax && day >= 5'd1)
    else $error("month or day out of range");

  // a good parse never has a day beyond the month length
  a_okday: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> day <= month_len(month))
    else $error("ok result with day beyond month length");

endmodule

bind dotted_date_parser_to_day_count_top dpd_checker u_dpd_checker (.*);

// ----- tb/tb_dotted_date_parser_to_day_count_top.sv -----
// ----------------------------------------------------------------------------
// tb_dotted_date_parser_to_day_count_top
// Self-checking bench: streams date strings byte by byte into the parser,
// predicts each day count from a behavioral parser kept here, and compares
// every result item field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_dotted_date_parser_to_day_count_top
  import dpd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int YearBits     = YearBitsDefault;
  localparam int YearLimit    = 1 << YearBits;
  localparam int RandomItems  = 750;
  localparam int IdlePct      = 13;
  localparam int QuietLimit   = 2000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 80;

  // one text byte as offered to the block
  typedef struct {
    logic [InDataW-1:0] ch;
    logic               fin;
  } text_byte_t;

  // one parsed date as the block reports it
  typedef struct {
    logic [TotalW-1:0]   total;
    logic [YearOutW-1:0] year;
    logic [MonthW-1:0]   month;
    logic [DayW-1:0]     day;
    logic                ok;
  } date_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;

  dotted_date_parser_to_day_count_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // common-year calendar
  int month_days [12]  = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int days_ahead [12]  = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  text_byte_t   text_bytes[$];
  date_result_t dates_due[$];
  int           mismatches  = 0;
  int           bytes_taken = 0;
  int           hold_left   = 0;
  int           hold_round  = 0;
  int           quiet_cycles = 0;
  logic         calm;

  // stretch of traffic with no idling on either side
  assign calm = (bytes_taken >= 300) && (bytes_taken < 480);

  // parser state mirrored at the block's widths
  phase_t              parse_phase;
  logic [YearBits:0]   year_acc;
  logic [3:0]          month_acc;
  logic [5:0]          day_acc;
  logic                digits_seen;
  logic [MonthW-1:0]   month_keep;
  logic [DayW-1:0]     day_keep;
  logic                parse_failed;

  task automatic clear_parse();
    parse_phase  = PH_YEAR;
    year_acc     = '0;
    month_acc    = '0;
    day_acc      = '0;
    digits_seen  = 1'b0;
    month_keep   = 4'd1;
    day_keep     = 5'd1;
    parse_failed = 1'b0;
  endtask

  task automatic give_up();
    parse_failed = 1'b1;
    parse_phase  = PH_SKIP;
  endtask

  // close the field that is open, on a dot, another byte or end of text
  task automatic close_field(input end_kind_t how);
    case (parse_phase)
      PH_YEAR: begin
        if (!digits_seen || year_acc >= YearLimit) begin
          year_acc   = '0;
          month_keep = 4'd1;
          day_keep   = 5'd1;
          give_up();
        end else if (how == END_DOT) begin
          parse_phase = PH_MONTH;
          digits_seen = 1'b0;
        end else if (how == END_OTHER) begin
          give_up();
        end
      end
      PH_MONTH: begin
        if (!digits_seen || month_acc < 1 || month_acc > MonthMax) begin
          give_up();
        end else begin
          month_keep = month_acc;
          if (how == END_DOT) begin
            parse_phase = PH_DAY;
            digits_seen = 1'b0;
          end else if (how == END_OTHER) begin
            give_up();
          end
        end
      end
      PH_DAY: begin
        if (!digits_seen || day_acc < 1 || day_acc > month_days[int'(month_keep) - 1]) begin
          give_up();
        end else begin
          day_keep = day_acc[DayW-1:0];
          if (how != END_STRING) give_up();
        end
      end
      default: ;
    endcase
  endtask

  // advance the parser by one accepted byte, queue the date on the final one
  task automatic parse_byte(input logic [InDataW-1:0] ch, input logic fin);
    int           v;
    int           t;
    date_result_t res;
    if (parse_phase != PH_SKIP) begin
      if (ch >= CharZero && ch <= CharNine) begin
        v = int'(ch - CharZero);
        digits_seen = 1'b1;
        case (parse_phase)
          PH_YEAR: begin
            v = int'(year_acc) * Ten + v;
            year_acc = (year_acc >= YearLimit || v > YearLimit) ?
                       (YearBits+1)'(YearLimit) : v[YearBits:0];
          end
          PH_MONTH: begin
            v = int'(month_acc) * Ten + v;
            month_acc = (v > int'(MonthSat)) ? MonthSat : v[3:0];
          end
          default: begin
            v = int'(day_acc) * Ten + v;
            day_acc = (v > int'(DaySat)) ? DaySat : v[5:0];
          end
        endcase
      end else begin
        close_field(ch == CharDot ? END_DOT : END_OTHER);
      end
    end
    if (fin) begin
      if (parse_phase != PH_SKIP) close_field(END_STRING);
      t = int'(year_acc) * DaysPerYear + days_ahead[int'(month_keep) - 1] + int'(day_keep) - 1;
      res.total = t[TotalW-1:0];
      res.year  = year_acc[YearOutW-1:0];
      res.month = month_keep;
      res.day   = day_keep;
      res.ok    = !parse_failed;
      dates_due.push_back(res);
      clear_parse();
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // queue a text, marking its final byte when it closes the string
  task automatic add_text(input string s, input bit closes);
    text_byte_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.ch  = s[i];
      b.fin = closes && (i == s.len() - 1);
      text_bytes.push_back(b);
    end
  endtask

  // queue random bytes over the whole byte range
  task automatic add_noise(input int n, input bit closes);
    text_byte_t b;
    for (int i = 0; i < n; i++) begin
      b.ch  = 8'($urandom_range(0, 255));
      b.fin = closes && (i == n - 1);
      text_bytes.push_back(b);
    end
  endtask

  // decimal text of a field, empty for a missing field, maybe zero padded
  function automatic string field_text(input int v);
    string s;
    if (v < 0) return "";
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) s = {"0", s};
    return s;
  endfunction

  function automatic int pick_year();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return YearLimit - 1 - $urandom_range(0, 3);
      1: return YearLimit + $urandom_range(0, 5000);
      2: return $urandom_range(100000, 99999999);
      3: return $urandom_range(0, 9);
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  function automatic int pick_month();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 12);
    if (r < 90) return 0;
    if (r < 94) return $urandom_range(13, 15);
    if (r < 97) return $urandom_range(16, 99);
    return -1;
  endfunction

  function automatic int pick_day(input int m);
    int r;
    int len;
    len = (m >= 1 && m <= 12) ? month_days[m - 1] : 31;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, len);
    if (r < 89) return 0;
    if (r < 93) return $urandom_range(len + 1, len + 2);
    if (r < 97) return $urandom_range(32, 99);
    return -1;
  endfunction

  // separator, mostly a dot
  function automatic string pick_sep();
    string seps;
    int    k;
    seps = "-/: a";
    if ($urandom_range(0, 99) < 95) return ".";
    k = $urandom_range(0, seps.len() - 1);
    return seps.substr(k, k);
  endfunction

  // stimulus, reset and end of run
  initial begin
    string s;
    string alphabet;
    int    m;
    int    k;
    int    fields;
    int    base;
    clear_parse();
    alphabet = "0123456789.x";

    // directed: year extremes, overflow, missing year, bad separator,
    // month and day range, trailing text
    add_text("0", 1'b1);
    add_text("65535.12.31", 1'b1);
    add_text("65536", 1'b1);
    add_text(".", 1'b1);
    add_text("2x", 1'b1);
    add_text("3.0", 1'b1);
    add_text("9.2.29", 1'b1);
    add_text("4.4.1.", 1'b1);
    base = text_bytes.size();

    // random: mostly well-formed dates, mixed with short strings and noise
    while (text_bytes.size() < base + RandomItems) begin
      k = $urandom_range(0, 99);
      if (k < 65) begin
        fields = $urandom_range(0, 99) < 10 ? 1 : ($urandom_range(0, 99) < 17 ? 2 : 3);
        s = field_text(pick_year());
        m = pick_month();
        if (fields >= 2) s = {s, pick_sep(), field_text(m)};
        if (fields == 3) s = {s, pick_sep(), field_text(pick_day(m))};
        if ($urandom_range(0, 9) == 0) begin
          add_text(s, 1'b0);
          add_noise($urandom_range(1, 3), 1'b1);
        end else begin
          add_text(s, 1'b1);
        end
      end else if (k < 85) begin
        s = "";
        fields = $urandom_range(1, 3);
        for (int i = 0; i < fields; i++) begin
          m = $urandom_range(0, alphabet.len() - 1);
          s = {s, alphabet.substr(m, m)};
        end
        add_text(s, 1'b1);
      end else begin
        add_noise($urandom_range(1, 6), 1'b1);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (text_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (dates_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_dotted_date_parser_to_day_count_top passed");
    end else begin
      $display("tb_dotted_date_parser_to_day_count_top failed");
    end
    $finish;
  end

  // sender: offer the next byte, hold it until taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tlast);
        bytes_taken <= bytes_taken + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (text_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= text_bytes[0].ch;
          s_tlast  <= text_bytes[0].fin;
          void'(text_bytes.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus two long hold-offs that back up the queue
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_round < 2 && bytes_taken >= (hold_round == 0 ? 150 : 600)) begin
      m_tready   <= 1'b0;
      hold_left  <= HoldCycles;
      hold_round <= hold_round + 1;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // check each result item against the oldest predicted date
  always @(posedge clk) begin : check_dates
    date_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (dates_due.size() == 0) begin
        report_mismatch("unexpected result, day_count", int'(m_tdata[TotalW-1:0]), 0);
      end else begin
        want = dates_due.pop_front();
        if (m_tdata[TotalW-1:0] !== want.total)
          report_mismatch("day_count", int'(m_tdata[TotalW-1:0]), int'(want.total));
        if (m_tdata[TotalW +: YearOutW] !== want.year)
          report_mismatch("year", int'(m_tdata[TotalW +: YearOutW]), int'(want.year));
        if (m_tdata[TotalW+YearOutW +: MonthW] !== want.month)
          report_mismatch("month", int'(m_tdata[TotalW+YearOutW +: MonthW]),
                          int'(want.month));
        if (m_tdata[TotalW+YearOutW+MonthW +: DayW] !== want.day)
          report_mismatch("day", int'(m_tdata[TotalW+YearOutW+MonthW +: DayW]),
                          int'(want.day));
        if (m_tuser !== want.ok)
          report_mismatch("ok", int'(m_tuser), int'(want.ok));
      end
    end
  end

  // watchdog on cycles with no item taken on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb_dotted_date_parser_to_day_count_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
